// ===== hdl/gta_pkg.sv =====
// Shared constants, codes and helpers for the greedy tile assembler.
package gta_pkg;

    localparam int GRID_SIDE_DEF  = 4;
    localparam int TILE_COUNT_DEF = 16;
    localparam int SCORE_BITS_DEF = 24;
    localparam int MAX_PLACE      = 16;
    localparam int TILE_W         = 4;
    localparam int PIX_W          = 8;
    localparam int SAD_W          = 10;

    localparam logic CMD_ACCUM = 1'b0;
    localparam logic CMD_SOLVE = 1'b1;
    localparam logic DIR_EAST  = 1'b0;
    localparam logic DIR_NORTH = 1'b1;

    function automatic logic [PIX_W-1:0] absdiff(input logic [PIX_W-1:0] x,
                                                 input logic [PIX_W-1:0] y);
        return (x > y) ? x - y : y - x;
    endfunction

endpackage

// ===== hdl/gta_if.sv =====
// Valid/ready channel interfaces for pixel-pair items and placement items.
interface gta_in_if;
    logic                       valid;
    logic                       ready;
    logic                       cmd;
    logic                       direction;
    logic [gta_pkg::TILE_W-1:0] tile_a;
    logic [gta_pkg::TILE_W-1:0] tile_b;
    logic                       first_pixel;
    logic [gta_pkg::PIX_W-1:0]  red_a;
    logic [gta_pkg::PIX_W-1:0]  green_a;
    logic [gta_pkg::PIX_W-1:0]  blue_a;
    logic [gta_pkg::PIX_W-1:0]  red_b;
    logic [gta_pkg::PIX_W-1:0]  green_b;
    logic [gta_pkg::PIX_W-1:0]  blue_b;

    modport source (output valid, cmd, direction, tile_a, tile_b, first_pixel,
                    red_a, green_a, blue_a, red_b, green_b, blue_b, input ready);
    modport sink   (input valid, cmd, direction, tile_a, tile_b, first_pixel,
                    red_a, green_a, blue_a, red_b, green_b, blue_b, output ready);
endinterface

interface gta_out_if;
    logic                       valid;
    logic                       ready;
    logic [gta_pkg::TILE_W-1:0] grid_position;
    logic [gta_pkg::TILE_W-1:0] tile_id;
    logic                       last_placement;

    modport source (output valid, grid_position, tile_id, last_placement, input ready);
    modport sink   (input valid, grid_position, tile_id, last_placement, output ready);
endinterface

// ===== hdl/gta_ram.sv =====
// Generic simple dual-port RAM, one write port, one registered read port.
module gta_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 512
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ===== hdl/greedy_tile_assembler.sv =====
// Greedy tile assembler: edge score accumulation and greedy grid placement.
//
//  channel      dir  handshake      payload
//  i_cmd_ch     in   valid/ready    cmd, direction, tile_a/b, first_pixel, rgb a/b
//  o_place_ch   out  valid/ready    grid_position, tile_id, last_placement
//
// Accumulate items are taken one per cycle while idle: read the score RAM, add the SAD
// in the next cycle and write back, with a bypass of the previous write.
// A solve item scans the north and west scores of every tile for the corner, then each
// candidate tile for every further position, all through the single RAM read port.
// Input ready is low for the whole solve run; a stalled output holds the run.
// Synchronous active-low reset; the score RAM is not cleared.
module greedy_tile_assembler #(
    parameter int GRID_SIDE  = gta_pkg::GRID_SIDE_DEF,
    parameter int TILE_COUNT = gta_pkg::TILE_COUNT_DEF,
    parameter int SCORE_BITS = gta_pkg::SCORE_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    gta_in_if.sink     i_cmd_ch,
    gta_out_if.source  o_place_ch
);
    localparam int TW    = $clog2(TILE_COUNT);
    localparam int AW    = 1 + 2 * TW;
    localparam int DEPTH = 1 << AW;
    localparam int CW    = $clog2(GRID_SIDE);
    localparam int KW    = gta_pkg::TILE_W;
    localparam int POS   = (GRID_SIDE * GRID_SIDE > gta_pkg::MAX_PLACE) ?
                           gta_pkg::MAX_PLACE : GRID_SIDE * GRID_SIDE;
    localparam logic [TW-1:0] T_LAST   = TW'(TILE_COUNT - 1);
    localparam logic [CW-1:0] COL_LAST = CW'(GRID_SIDE - 1);
    localparam logic [KW-1:0] K_LAST   = KW'(POS - 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CORN  = 3'd1;
    localparam logic [2:0] S_NEIGH = 3'd2;
    localparam logic [2:0] S_DRAIN = 3'd3;
    localparam logic [2:0] S_EMIT  = 3'd4;

    logic [2:0] r_state;

    // accumulate front end
    logic                        in_fire, acc0;
    logic [AW-1:0]               addr0;
    logic [gta_pkg::SAD_W-1:0]   sad0;
    logic                        r_s1v, r_s1first;
    logic [AW-1:0]               r_s1addr;
    logic [gta_pkg::SAD_W-1:0]   r_s1sad;
    logic                        r_wbv;
    logic [AW-1:0]               r_wbaddr;
    logic [SCORE_BITS-1:0]       r_wbdata;
    logic [SCORE_BITS-1:0]       cur, wdata, rdata;
    logic [SCORE_BITS:0]         sum;

    // scan counters and read tags
    logic [TW-1:0]  r_t, r_j, r_ref;
    logic           r_h, r_dir;
    logic           issue;
    logic [AW-1:0]  scan_addr, raddr;
    logic           r_tv, r_tkind, r_th;
    logic [TW-1:0]  r_tt, r_tj;

    // corner search
    logic [SCORE_BITS-1:0] r_mn, r_mw, mn_new, mw_new;
    logic [SCORE_BITS:0]   r_best, total;
    logic [TW-1:0]         r_corner;
    logic                  gt;

    // neighbor search
    logic                  r_found, cand;
    logic [SCORE_BITS-1:0] r_nbest;
    logic [TW-1:0]         r_ngot;

    // placement
    logic [TW-1:0]         r_pend;
    logic                  r_pok;
    logic [KW-1:0]         r_k;
    logic [CW-1:0]         r_col, n_col;
    logic [KW-1:0]         r_placed [gta_pkg::MAX_PLACE];
    logic [KW:0]           up_idx;
    logic [TILE_COUNT-1:0] r_unplaced;
    logic                  r_ov, r_olast;
    logic [KW-1:0]         r_opos, r_otile;
    logic                  out_free;

    assign i_cmd_ch.ready = (r_state == S_IDLE);
    assign in_fire = i_cmd_ch.valid && i_cmd_ch.ready;
    assign acc0 = in_fire && (i_cmd_ch.cmd == gta_pkg::CMD_ACCUM) &&
                  (8'(i_cmd_ch.tile_a) < 8'(TILE_COUNT)) &&
                  (8'(i_cmd_ch.tile_b) < 8'(TILE_COUNT));
    assign addr0 = {i_cmd_ch.direction, TW'(i_cmd_ch.tile_a), TW'(i_cmd_ch.tile_b)};
    assign sad0 = gta_pkg::SAD_W'(gta_pkg::absdiff(i_cmd_ch.red_a, i_cmd_ch.red_b))
                + gta_pkg::SAD_W'(gta_pkg::absdiff(i_cmd_ch.green_a, i_cmd_ch.green_b))
                + gta_pkg::SAD_W'(gta_pkg::absdiff(i_cmd_ch.blue_a, i_cmd_ch.blue_b));

    // read-modify-write; the write of the cycle before is not yet in the RAM output
    assign cur = r_s1first ? '0 :
                 (r_wbv && (r_wbaddr == r_s1addr)) ? r_wbdata : rdata;
    assign sum = (SCORE_BITS + 1)'(cur) + (SCORE_BITS + 1)'(r_s1sad);
    assign wdata = sum[SCORE_BITS] ? '1 : sum[SCORE_BITS-1:0];

    // corner scan: north row of t, then west column of t
    always_comb begin
        if (r_state == S_CORN) begin
            scan_addr = r_h ? {gta_pkg::DIR_EAST, r_j, r_t} : {gta_pkg::DIR_NORTH, r_t, r_j};
        end else begin
            scan_addr = r_dir ? {gta_pkg::DIR_NORTH, r_j, r_ref} : {gta_pkg::DIR_EAST, r_ref, r_j};
        end
    end
    assign issue = (r_state == S_CORN) || (r_state == S_NEIGH);
    assign raddr = (r_state == S_IDLE) ? addr0 : scan_addr;

    gta_ram #(.WIDTH(SCORE_BITS), .DEPTH(DEPTH)) u_scores (
        .i_clk   (i_clk),
        .i_we    (r_s1v),
        .i_waddr (r_s1addr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    assign mn_new = ((r_tj == '0) || (rdata < r_mn)) ? rdata : r_mn;
    assign mw_new = ((r_tj == '0) || (rdata < r_mw)) ? rdata : r_mw;
    assign total  = (SCORE_BITS + 1)'(r_mn) + (SCORE_BITS + 1)'(mw_new);
    assign gt     = total > r_best;
    assign cand   = (r_tj != r_ref) && r_unplaced[r_tj] && (!r_found || (rdata < r_nbest));

    assign out_free = !r_ov || o_place_ch.ready;
    assign n_col    = (r_col == COL_LAST) ? '0 : r_col + 1'b1;
    assign up_idx   = (KW + 1)'(r_k) + 1'b1 - (KW + 1)'(GRID_SIDE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_s1v      <= 1'b0;
            r_wbv      <= 1'b0;
            r_tv       <= 1'b0;
            r_ov       <= 1'b0;
            r_unplaced <= '1;
        end else begin
            r_s1v     <= acc0;
            r_s1addr  <= addr0;
            r_s1sad   <= sad0;
            r_s1first <= i_cmd_ch.first_pixel;
            r_wbv     <= r_s1v;
            r_wbaddr  <= r_s1addr;
            r_wbdata  <= wdata;

            r_tv    <= issue;
            r_tkind <= (r_state == S_NEIGH);
            r_tt    <= r_t;
            r_th    <= r_h;
            r_tj    <= r_j;

            // in S_EMIT a taken item is replaced by the next one below
            if (o_place_ch.valid && o_place_ch.ready && (r_state != S_EMIT)) begin
                r_ov <= 1'b0;
            end

            // returned read data
            if (r_tv && !r_tkind) begin
                if (!r_th) begin
                    r_mn <= mn_new;
                end else begin
                    r_mw <= mw_new;
                    if (r_tj == T_LAST) begin
                        if (gt) begin
                            r_best   <= total;
                            r_corner <= r_tt;
                        end
                        if (r_tt == T_LAST) begin
                            r_pend  <= gt ? r_tt : r_corner;
                            r_pok   <= 1'b1;
                            r_state <= S_EMIT;
                        end
                    end
                end
            end
            if (r_tv && r_tkind) begin
                if (cand) begin
                    r_found <= 1'b1;
                    r_nbest <= rdata;
                    r_ngot  <= r_tj;
                end
                if (r_tj == T_LAST) begin
                    r_pend  <= cand ? r_tj : (r_found ? r_ngot : '0);
                    r_pok   <= cand || r_found;
                    r_state <= S_EMIT;
                end
            end

            unique case (r_state)
                S_IDLE: begin
                    if (in_fire && (i_cmd_ch.cmd == gta_pkg::CMD_SOLVE)) begin
                        r_unplaced <= '1;
                        r_k        <= '0;
                        r_col      <= '0;
                        r_t        <= '0;
                        r_h        <= 1'b0;
                        r_j        <= '0;
                        r_best     <= '0;
                        r_corner   <= '0;
                        r_state    <= S_CORN;
                    end
                end
                S_CORN: begin
                    if (r_j == T_LAST) begin
                        r_j <= '0;
                        r_h <= !r_h;
                        if (r_h) begin
                            r_t <= r_t + 1'b1;
                            if (r_t == T_LAST) begin
                                r_state <= S_DRAIN;
                            end
                        end
                    end else begin
                        r_j <= r_j + 1'b1;
                    end
                end
                S_NEIGH: begin
                    r_j <= r_j + 1'b1;
                    if (r_j == T_LAST) begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    // last read in flight; the data path above moves on
                end
                S_EMIT: begin
                    if (out_free) begin
                        r_ov        <= 1'b1;
                        r_opos      <= r_k;
                        r_otile     <= KW'(r_pend);
                        r_olast     <= (r_k == K_LAST);
                        r_placed[r_k] <= KW'(r_pend);
                        if (r_pok) begin
                            r_unplaced[r_pend] <= 1'b0;
                        end
                        if (r_k == K_LAST) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_k     <= r_k + 1'b1;
                            r_col   <= n_col;
                            r_j     <= '0;
                            r_found <= 1'b0;
                            r_dir   <= (n_col == '0) ? gta_pkg::DIR_NORTH : gta_pkg::DIR_EAST;
                            r_ref   <= (n_col == '0) ? TW'(r_placed[up_idx[KW-1:0]])
                                                     : TW'(KW'(r_pend));
                            r_state <= S_NEIGH;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_place_ch.valid          = r_ov;
    assign o_place_ch.grid_position  = r_opos;
    assign o_place_ch.tile_id        = r_otile;
    assign o_place_ch.last_placement = r_olast;
endmodule

// ===== hdl/gta_checker.sv =====
// Port-level checks for the greedy tile assembler, bound to the top level.
module gta_checker #(
    parameter int GRID_SIDE = gta_pkg::GRID_SIDE_DEF
) (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_in_valid,
    input logic                       i_in_ready,
    input logic                       i_in_cmd,
    input logic                       i_out_valid,
    input logic                       i_out_ready,
    input logic [gta_pkg::TILE_W-1:0] i_out_pos,
    input logic [gta_pkg::TILE_W-1:0] i_out_tile,
    input logic                       i_out_last
);
    localparam int POS = (GRID_SIDE * GRID_SIDE > gta_pkg::MAX_PLACE) ?
                         gta_pkg::MAX_PLACE : GRID_SIDE * GRID_SIDE;
    localparam logic [gta_pkg::TILE_W-1:0] K_LAST = gta_pkg::TILE_W'(POS - 1);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_pos) &&
                                        $stable(i_out_tile) && $stable(i_out_last))
        else $error("placement changed while stalled");

    a_last_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_out_last == (i_out_pos == K_LAST)))
        else $error("last flag not on final grid position");

    a_solve_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && (i_in_cmd == gta_pkg::CMD_SOLVE) |=> !i_in_ready)
        else $error("input taken during solve run");

    a_reset_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("placement valid after reset");
endmodule

bind greedy_tile_assembler gta_checker #(.GRID_SIDE(GRID_SIDE)) u_gta_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_cmd_ch.valid),
    .i_in_ready  (i_cmd_ch.ready),
    .i_in_cmd    (i_cmd_ch.cmd),
    .i_out_valid (o_place_ch.valid),
    .i_out_ready (o_place_ch.ready),
    .i_out_pos   (o_place_ch.grid_position),
    .i_out_tile  (o_place_ch.tile_id),
    .i_out_last  (o_place_ch.last_placement)
);

// ===== sim/greedy_tile_assembler_test.sv =====
// Self-checking testbench for the greedy tile assembler: scoring and placement.
module greedy_tile_assembler_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TILES      = gta_pkg::TILE_COUNT_DEF;
    localparam int SIDE       = gta_pkg::GRID_SIDE_DEF;
    localparam int SBITS      = gta_pkg::SCORE_BITS_DEF;
    localparam int MAXP       = gta_pkg::MAX_PLACE;
    localparam int TW         = gta_pkg::TILE_W;
    localparam int PW         = gta_pkg::PIX_W;
    localparam int STALL_MAX  = 20000;
    localparam int SETTLE     = 40;
    localparam int HOLD_LEN   = 3000;

    typedef struct packed {
        logic          cmd;
        logic          direction;
        logic [TW-1:0] tile_a;
        logic [TW-1:0] tile_b;
        logic          first_pixel;
        logic [PW-1:0] red_a, green_a, blue_a;
        logic [PW-1:0] red_b, green_b, blue_b;
    } pixel_item_t;

    typedef struct packed {
        logic [TW-1:0] grid_position;
        logic [TW-1:0] tile_id;
        logic          last_placement;
    } placement_t;

    logic i_clk;
    logic i_rst_n;

    gta_in_if  cmd_ch ();
    gta_out_if place_ch ();

    greedy_tile_assembler i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd_ch   (cmd_ch),
        .o_place_ch (place_ch)
    );

    // shadow of the score store and the expected placements
    logic [SBITS-1:0] shadow_scores [2][TILES][TILES];
    placement_t       placement_q [$];

    int errors = 0;
    int items_sent = 0;
    int solves_sent = 0;
    int placements_seen = 0;
    int src_idle_pct = 0;
    int snk_idle_pct = 0;
    int hold_requests = 0;
    int hold_granted = 0;
    int hold_cycles = 0;
    int quiet_cycles = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [9:0] pixel_sad(pixel_item_t it);
        logic [9:0] r, g, b;
        r = 10'(gta_pkg::absdiff(it.red_a, it.red_b));
        g = 10'(gta_pkg::absdiff(it.green_a, it.green_b));
        b = 10'(gta_pkg::absdiff(it.blue_a, it.blue_b));
        return r + g + b;
    endfunction

    // greedy fill of the grid from the shadow scores
    function automatic void predict_placements();
        logic [TILES-1:0]  free_tiles;
        logic [TW-1:0]     order [MAXP];
        logic [SBITS:0]    best_total, total;
        logic [SBITS-1:0]  min_n, min_w, best_s, s;
        int corner, ref_tile, pick, positions;
        bit found;
        placement_t p;
        positions = (SIDE * SIDE > MAXP) ? MAXP : SIDE * SIDE;
        free_tiles = '1;
        best_total = '0;
        corner = 0;
        for (int t = 0; t < TILES; t++) begin
            min_n = shadow_scores[gta_pkg::DIR_NORTH][t][0];
            min_w = shadow_scores[gta_pkg::DIR_EAST][0][t];
            for (int j = 1; j < TILES; j++) begin
                if (shadow_scores[gta_pkg::DIR_NORTH][t][j] < min_n)
                    min_n = shadow_scores[gta_pkg::DIR_NORTH][t][j];
                if (shadow_scores[gta_pkg::DIR_EAST][j][t] < min_w)
                    min_w = shadow_scores[gta_pkg::DIR_EAST][j][t];
            end
            total = {1'b0, min_n} + {1'b0, min_w};
            if (total > best_total) begin
                best_total = total;
                corner = t;
            end
        end
        for (int k = 0; k < positions; k++) begin
            pick = 0;
            found = 1'b0;
            if (k == 0) begin
                pick = corner;
                found = 1'b1;
            end else begin
                // left neighbor inside a row, tile above at a row start
                ref_tile = (k % SIDE != 0) ? order[k-1] : order[k-SIDE];
                best_s = '0;
                for (int c = 0; c < TILES; c++) begin
                    if (c == ref_tile || !free_tiles[c]) continue;
                    s = (k % SIDE != 0) ? shadow_scores[gta_pkg::DIR_EAST][ref_tile][c]
                                        : shadow_scores[gta_pkg::DIR_NORTH][c][ref_tile];
                    if (!found || s < best_s) begin
                        found = 1'b1;
                        best_s = s;
                        pick = c;
                    end
                end
            end
            if (found) free_tiles[pick] = 1'b0;
            else pick = 0;
            order[k] = pick[TW-1:0];
            p.grid_position  = k[TW-1:0];
            p.tile_id        = pick[TW-1:0];
            p.last_placement = (k + 1 == positions);
            placement_q.push_back(p);
        end
    endfunction

    function automatic void predict_item(pixel_item_t it);
        logic [SBITS:0] sum;
        if (it.cmd == gta_pkg::CMD_SOLVE) begin
            predict_placements();
            return;
        end
        sum = it.first_pixel ? '0 : {1'b0, shadow_scores[it.direction][it.tile_a][it.tile_b]};
        sum = sum + (SBITS + 1)'(pixel_sad(it));
        if (sum[SBITS]) sum = {1'b0, {SBITS{1'b1}}};   // saturate
        shadow_scores[it.direction][it.tile_a][it.tile_b] = sum[SBITS-1:0];
    endfunction

    // offers one item, with a random gap first, and waits for acceptance
    task automatic send_item(pixel_item_t it);
        while ($urandom_range(99) < src_idle_pct) begin
            cmd_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        cmd_ch.valid       <= 1'b1;
        cmd_ch.cmd         <= it.cmd;
        cmd_ch.direction   <= it.direction;
        cmd_ch.tile_a      <= it.tile_a;
        cmd_ch.tile_b      <= it.tile_b;
        cmd_ch.first_pixel <= it.first_pixel;
        cmd_ch.red_a       <= it.red_a;
        cmd_ch.green_a     <= it.green_a;
        cmd_ch.blue_a      <= it.blue_a;
        cmd_ch.red_b       <= it.red_b;
        cmd_ch.green_b     <= it.green_b;
        cmd_ch.blue_b      <= it.blue_b;
        @(posedge i_clk);
        while (!cmd_ch.ready) @(posedge i_clk);
        predict_item(it);
        items_sent++;
        if (it.cmd == gta_pkg::CMD_SOLVE) solves_sent++;
    endtask

    task automatic stop_offering();
        cmd_ch.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // sender pause until every placement is back, then the write-back settles
    task automatic wait_drain();
        stop_offering();
        while (placement_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    function automatic pixel_item_t accum_item(logic dir, int a, int b, logic first);
        pixel_item_t it;
        it = pixel_item_t'($bits(pixel_item_t)'({$urandom, $urandom}));
        it.cmd         = gta_pkg::CMD_ACCUM;
        it.direction   = dir;
        it.tile_a      = a[TW-1:0];
        it.tile_b      = b[TW-1:0];
        it.first_pixel = first;
        // near-matching edges now and then, so low scores compete
        if ($urandom_range(3) == 0) begin
            it.red_b   = it.red_a ^ PW'($urandom_range(3));
            it.green_b = it.green_a;
            it.blue_b  = it.blue_a ^ PW'($urandom_range(3));
        end
        return it;
    endfunction

    function automatic pixel_item_t solve_item();
        pixel_item_t it;
        it = pixel_item_t'($bits(pixel_item_t)'({$urandom, $urandom}));
        it.cmd = gta_pkg::CMD_SOLVE;
        return it;
    endfunction

    // every entry gets written before any solve reads it
    task automatic fill_all_scores(bit flat);
        pixel_item_t it;
        for (int d = 0; d < 2; d++)
            for (int a = 0; a < TILES; a++)
                for (int b = 0; b < TILES; b++) begin
                    it = accum_item(d[0], a, b, 1'b1);
                    if (flat) begin
                        it.red_b = it.red_a;
                        it.green_b = it.green_a;
                        it.blue_b = it.blue_a;
                    end
                    send_item(it);
                end
    endtask

    // all scores equal: corner falls to tile 0, neighbors to the lowest index
    task automatic test_tie_breaks();
        fill_all_scores(1'b1);
        send_item(solve_item());
        wait_drain();
    endtask

    // pixel extremes, first-pixel clear and accumulation on top
    task automatic test_pixel_extremes();
        pixel_item_t it;
        it = accum_item(gta_pkg::DIR_EAST, 0, 15, 1'b1);
        {it.red_a, it.green_a, it.blue_a} = '1;
        {it.red_b, it.green_b, it.blue_b} = '0;
        send_item(it);
        it.first_pixel = 1'b0;
        {it.red_a, it.green_a, it.blue_a} = '0;
        {it.red_b, it.green_b, it.blue_b} = '1;
        send_item(it);
        it = accum_item(gta_pkg::DIR_NORTH, 15, 0, 1'b1);
        {it.red_a, it.green_a, it.blue_a} = '0;
        {it.red_b, it.green_b, it.blue_b} = '0;
        send_item(it);
        it = accum_item(gta_pkg::DIR_NORTH, 7, 7, 1'b1);
        send_item(it);
        send_item(accum_item(gta_pkg::DIR_NORTH, 7, 7, 1'b0));
        send_item(solve_item());
        send_item(solve_item());   // back-to-back solves
        wait_drain();
    endtask

    // receiver holds off while solves and pixels keep coming
    task automatic test_backpressure();
        hold_requests++;
        send_item(solve_item());
        for (int i = 0; i < 8; i++)
            send_item(accum_item(1'($urandom), $urandom_range(TILES - 1),
                                 $urandom_range(TILES - 1), 1'b0));
        send_item(solve_item());
        wait_drain();
    endtask

    // edge runs of random length with random content, some noise, solves
    task automatic test_random_runs(int count);
        int target, len, a, b;
        logic dir;
        target = items_sent + count;
        while (items_sent < target) begin
            if ($urandom_range(9) == 0) begin
                send_item(solve_item());
            end else if ($urandom_range(9) < 8) begin
                dir = 1'($urandom);
                a = $urandom_range(TILES - 1);
                b = $urandom_range(TILES - 1);
                len = $urandom_range(1, 5);
                for (int i = 0; i < len; i++) send_item(accum_item(dir, a, b, i == 0));
            end else begin
                send_item(accum_item(1'($urandom), $urandom_range(TILES - 1),
                                     $urandom_range(TILES - 1), 1'($urandom)));
            end
        end
        send_item(solve_item());
        wait_drain();
    endtask

    // result receiver: ready pattern plus long hold-off on request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            place_ch.ready <= 1'b0;
        end else if (hold_requests != hold_granted) begin
            hold_granted   <= hold_requests;
            hold_cycles    <= HOLD_LEN - 1;
            place_ch.ready <= 1'b0;
        end else if (hold_cycles > 0) begin
            hold_cycles    <= hold_cycles - 1;
            place_ch.ready <= 1'b0;
        end else begin
            place_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    // placement checker
    always @(posedge i_clk) begin
        placement_t want;
        if (i_rst_n && place_ch.valid && place_ch.ready) begin
            placements_seen++;
            if (placement_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected placement pos %0d tile %0d last %0b", $time,
                         place_ch.grid_position, place_ch.tile_id, place_ch.last_placement);
            end else begin
                want = placement_q.pop_front();
                if (place_ch.grid_position !== want.grid_position) begin
                    errors++;
                    $display("%0t: grid_position expected %0d actual %0d", $time,
                             want.grid_position, place_ch.grid_position);
                end
                if (place_ch.tile_id !== want.tile_id) begin
                    errors++;
                    $display("%0t: tile_id at %0d expected %0d actual %0d", $time,
                             want.grid_position, want.tile_id, place_ch.tile_id);
                end
                if (place_ch.last_placement !== want.last_placement) begin
                    errors++;
                    $display("%0t: last_placement at %0d expected %0b actual %0b", $time,
                             want.grid_position, want.last_placement,
                             place_ch.last_placement);
                end
            end
        end
    end

    // watchdog on cycles with no handshake on either channel
    always @(posedge i_clk) begin
        if (!i_rst_n || (cmd_ch.valid && cmd_ch.ready) || (place_ch.valid && place_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > STALL_MAX) begin
            $display("%0t: no progress for %0d cycles", $time, quiet_cycles);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        // known values from time zero
        i_rst_n              = 1'b0;
        cmd_ch.valid         = 1'b0;
        cmd_ch.cmd           = gta_pkg::CMD_ACCUM;
        cmd_ch.direction     = gta_pkg::DIR_EAST;
        cmd_ch.tile_a        = '0;
        cmd_ch.tile_b        = '0;
        cmd_ch.first_pixel   = 1'b0;
        cmd_ch.red_a         = '0;
        cmd_ch.green_a       = '0;
        cmd_ch.blue_a        = '0;
        cmd_ch.red_b         = '0;
        cmd_ch.green_b       = '0;
        cmd_ch.blue_b        = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        src_idle_pct = 25;
        snk_idle_pct = 46;
        test_tie_breaks();
        test_backpressure();
        src_idle_pct = 46;
        snk_idle_pct = 25;
        test_pixel_extremes();
        test_random_runs(12);
        src_idle_pct = 0;
        snk_idle_pct = 0;
        test_random_runs(12);

        wait_drain();
        $display("Sent %0d items with %0d solves; %0d placements checked.",
                 items_sent, solves_sent, placements_seen);
        $display("Covered tie breaks, pixel extremes, first-pixel clears, hold-off, edge runs.");
        if (errors == 0 && placement_q.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("%0d errors, %0d placements missing", errors, placement_q.size());
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// ===== greedy_tile_assembler.f =====
hdl/gta_pkg.sv
hdl/gta_if.sv
hdl/gta_ram.sv
hdl/greedy_tile_assembler.sv
hdl/gta_checker.sv
sim/greedy_tile_assembler_test.sv
